// File: sv/imadec_pkg.sv
package imadec_pkg;

  // Sample counter width and the compare width that covers counter and limit
  localparam int unsigned CountBits = 16;
  localparam int unsigned CmpW      = ((CountBits > 16) ? CountBits : 16) + 1;

  localparam int unsigned MaxIndex  = 88;

  // Header byte positions; DataPhase means code bytes follow
  localparam logic [2:0] HdrPredLo = 3'd0;
  localparam logic [2:0] HdrPredHi = 3'd1;
  localparam logic [2:0] HdrIndex  = 3'd2;
  localparam logic [2:0] HdrRsvd   = 3'd3;
  localparam logic [2:0] DataPhase = 3'd4;

  // Command queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  typedef enum logic [1:0] {
    OpPredLo,
    OpPredHi,
    OpIndex,
    OpDecode
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       two_codes;
  } cmd_t;

  typedef logic [6:0]  idx_t;
  typedef logic [14:0] step_t;

  // IMA step size table
  function automatic step_t step_lookup(idx_t idx);
    step_t s;
    case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Step index adjustment by code magnitude
  function automatic logic signed [4:0] index_adjust(logic [2:0] mag);
    logic signed [4:0] a;
    case (mag)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage

// File: sv/imadec_if.sv
interface imadec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_block;
  logic       end_of_block;

  modport source (output valid, data_byte, start_of_block, end_of_block, input ready);
  modport sink   (input valid, data_byte, start_of_block, end_of_block, output ready);
endinterface

interface imadec_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last_of_run;

  modport source (output valid, sample, last_of_run, input ready);
  modport sink   (input valid, sample, last_of_run, output ready);
endinterface

interface imadec_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_limit;

  modport source (output valid, sample_limit, input ready);
  modport sink   (input valid, sample_limit, output ready);
endinterface

// File: sv/imadec_fifo.sv
module imadec_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  imadec_pkg::cmd_t    push_cmd_i,
  output logic                full_o,
  output logic                head_valid_o,
  output imadec_pkg::cmd_t    head_cmd_o,
  input  logic                pop_i
);
  import imadec_pkg::*;

  cmd_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wptr_q, rptr_q;
  logic [FifoAw:0]   cnt_q, cnt_d;

  assign full_o       = (cnt_q == (FifoAw + 1)'(FifoDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = mem_q[rptr_q];

  // Track fill level
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_cmd_i;
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("command queue overflow");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("command queue underflow");

endmodule

// File: sv/imadec_front.sv
module imadec_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  imadec_in_if.sink        in_ch,
  imadec_cfg_if.sink       cfg_ch,
  input  logic             full_i,
  output logic             push_o,
  output imadec_pkg::cmd_t push_cmd_o
);
  import imadec_pkg::*;

  localparam logic [CmpW-1:0] CntMaxW = CmpW'({CountBits{1'b1}});

  logic [15:0]          limit_q;
  logic                 active_q, active_d, active_eff;
  logic [2:0]           pos_q, pos_d, pos_eff;
  logic [CountBits-1:0] cnt_q, cnt_d, cnt_eff;
  logic [CmpW-1:0]      cnt_w, cnt_w1, lim_w;
  logic                 accept, ok0, ok1;

  assign in_ch.ready  = !full_i;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;

  // Classify the byte: header field load, code pair, or drop
  always_comb begin
    active_eff = in_ch.start_of_block || active_q;
    pos_eff    = in_ch.start_of_block ? HdrPredLo : pos_q;
    cnt_eff    = in_ch.start_of_block ? '0 : cnt_q;

    cnt_w  = CmpW'(cnt_eff);
    cnt_w1 = cnt_w + 1'b1;
    lim_w  = CmpW'(limit_q);
    ok0    = (cnt_w < lim_w) && (cnt_w < CntMaxW);
    ok1    = ok0 && (cnt_w1 < lim_w) && (cnt_w1 < CntMaxW);

    active_d = active_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    push_o   = 1'b0;
    push_cmd_o.op        = OpDecode;
    push_cmd_o.data      = in_ch.data_byte;
    push_cmd_o.two_codes = ok1;

    if (accept) begin
      active_d = active_eff && !in_ch.end_of_block;
      pos_d    = pos_eff;
      cnt_d    = cnt_eff;
      if (active_eff) begin
        if (pos_eff < DataPhase) begin
          pos_d = pos_eff + 1'b1;
          case (pos_eff)
            HdrPredLo: begin
              push_o        = 1'b1;
              push_cmd_o.op = OpPredLo;
            end
            HdrPredHi: begin
              push_o        = 1'b1;
              push_cmd_o.op = OpPredHi;
            end
            HdrIndex: begin
              push_o          = 1'b1;
              push_cmd_o.op   = OpIndex;
              push_cmd_o.data = (in_ch.data_byte > 8'(MaxIndex)) ?
                                8'(MaxIndex) : in_ch.data_byte;
            end
            default: push_o = 1'b0;
          endcase
        end else begin
          push_o = ok0;
          cnt_d  = cnt_eff + (ok1 ? CountBits'(2) : (ok0 ? CountBits'(1) : '0));
        end
      end
    end
  end

  // Hold block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= HdrPredLo;
      cnt_q    <= '0;
      limit_q  <= 16'hFFFF;
    end else begin
      active_q <= active_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      if (cfg_ch.valid) limit_q <= cfg_ch.sample_limit;
    end
  end

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= DataPhase)
    else $error("header position out of range");

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("push into full command queue");

endmodule

// File: sv/imadec_back.sv
module imadec_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  imadec_pkg::cmd_t head_cmd_i,
  output logic             pop_o,
  imadec_out_if.source     out_ch
);
  import imadec_pkg::*;

  logic signed [15:0] pred_q, pred_d, pred_sat;
  idx_t               idx_q, idx_d;
  logic               phase_q, phase_d;
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] out_sample_q, out_sample_d;
  logic               out_last_q, out_last_d;

  logic [3:0]         code;
  step_t              step;
  logic [16:0]        diff;
  logic signed [17:0] pred_x, diff_x, sum;
  logic signed [8:0]  ni;
  idx_t               ni_sat;
  logic               can_emit, last_code, do_decode;

  assign out_ch.valid       = out_valid_q;
  assign out_ch.sample      = out_sample_q;
  assign out_ch.last_of_run = out_last_q;

  // Decode one code from the registered predictor and step index
  always_comb begin
    code = phase_q ? head_cmd_i.data[7:4] : head_cmd_i.data[3:0];
    step = step_lookup(idx_q);
    diff = 17'(step >> 3)
         + (code[2] ? 17'(step) : 17'd0)
         + (code[1] ? 17'(step >> 1) : 17'd0)
         + (code[0] ? 17'(step >> 2) : 17'd0);
    pred_x = 18'(pred_q);
    diff_x = $signed({1'b0, diff});
    sum    = code[3] ? (pred_x - diff_x) : (pred_x + diff_x);
    if (sum > 18'sd32767)       pred_sat = 16'sh7FFF;
    else if (sum < -18'sd32768) pred_sat = -16'sh8000;
    else                        pred_sat = sum[15:0];

    ni = $signed({2'b00, idx_q}) + 9'(index_adjust(code[2:0]));
    if (ni < 9'sd0)                    ni_sat = '0;
    else if (ni > 9'sd0 + 9'(MaxIndex)) ni_sat = 7'(MaxIndex);
    else                               ni_sat = ni[6:0];
  end

  // Execute the head command and load the output register
  always_comb begin
    can_emit  = !out_valid_q || out_ch.ready;
    last_code = !head_cmd_i.two_codes || phase_q;
    do_decode = head_valid_i && (head_cmd_i.op == OpDecode) && can_emit;
    pop_o     = head_valid_i && ((head_cmd_i.op != OpDecode) || (can_emit && last_code));

    pred_d       = pred_q;
    idx_d        = idx_q;
    phase_d      = phase_q;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_ch.ready ? 1'b0 : out_valid_q;

    if (head_valid_i) begin
      case (head_cmd_i.op)
        OpPredLo: pred_d[7:0]  = head_cmd_i.data;
        OpPredHi: pred_d[15:8] = head_cmd_i.data;
        OpIndex:  idx_d        = head_cmd_i.data[6:0];
        OpDecode: begin
          if (can_emit) begin
            pred_d       = pred_sat;
            idx_d        = ni_sat;
            phase_d      = !last_code;
            out_sample_d = pred_sat;
            out_last_d   = last_code;
            out_valid_d  = 1'b1;
          end
        end
        default: pred_d = pred_q;
      endcase
    end
  end

  // Hold decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q      <= '0;
      idx_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pred_q      <= pred_d;
      idx_q       <= idx_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
  end

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 7'(MaxIndex))
    else $error("step index out of range");

  a_phase_on_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (head_valid_i && (head_cmd_i.op == OpDecode) && head_cmd_i.two_codes))
    else $error("second code pending without a two-code command");

  a_decode_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_decode |=> (out_valid_q && (out_sample_q == pred_q)))
    else $error("decoded sample not presented");

endmodule

// File: sv/ima_adpcm_block_decoder.sv
// IMA ADPCM block decoder. Bytes enter on in_ch, one per cycle while the
// four-entry command queue has room; decoded 16-bit samples leave on out_ch.
// The user is to write sample_limit on cfg_ch only while the block is idle;
// the block does not enforce this. The front end tracks the block header and
// the per-block sample count and turns header and code bytes into commands,
// dropping the reserved header byte and codes past the sample limit; the
// back end owns predictor and step index and runs one shared decode unit
// that yields one sample per cycle while out_ch takes them, so code bytes
// are bounded by that decode unit and the single-sample output register.
// With the queue and output register empty, a byte's first sample passes
// through the queue and then the output register before it is presented.
module ima_adpcm_block_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  imadec_in_if.sink     in_ch,
  imadec_out_if.source  out_ch,
  imadec_cfg_if.sink    cfg_ch
);
  import imadec_pkg::*;

  logic full, push, head_valid, pop;
  cmd_t push_cmd, head_cmd;

  imadec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .full_i     (full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  imadec_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  imadec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_ch       (out_ch)
  );

endmodule
